[rtl/msu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI-to-USB packet package
// Shared types, constants and status decode tables for the MIDI serial byte
// to USB-MIDI event packet converter.
// ----------------------------------------------------------------------------
package msu_pkg;

  localparam int unsigned CableWidth = 4;
  localparam int unsigned TdataInWidth = 8;
  localparam int unsigned TdataOutWidth = 32;

  localparam logic [7:0] SysexStart = 8'hF0;
  localparam logic [7:0] SysexEnd   = 8'hF7;

  localparam logic [1:0] CountFull = 2'd2;

  // Packed so that the header sits in the lowest bits of the output beat.
  typedef struct packed {
    logic [6:0] data_second;
    logic [6:0] data_first;
    logic [7:0] status_byte;
    logic [7:0] packet_header;
  } packet_t;

  localparam int unsigned PacketWidth = $bits(packet_t);

  // Number of data bytes that follow a given status byte.
  function automatic logic [1:0] expected_len(input logic [7:0] s);
    logic [1:0] len;
    case (s[7:4])
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = 2'd2;
      4'hC, 4'hD:                   len = 2'd1;
      default: begin
        case (s[3:0])
          4'h1, 4'h3:                             len = 2'd1;
          4'h6, 4'h7, 4'h8, 4'hA, 4'hB, 4'hC,
          4'hE, 4'hF:                             len = 2'd0;
          default:                                len = 2'd2;
        endcase
      end
    endcase
    return len;
  endfunction

  // USB-MIDI code index number for a status byte.
  function automatic logic [3:0] code_index(input logic [7:0] s);
    logic [3:0] cin;
    if (s[7:4] >= 4'h8 && s[7:4] <= 4'hE) begin
      cin = s[7:4];
    end else begin
      case (s[3:0])
        4'h1, 4'h3: cin = 4'h2;
        4'h2:       cin = 4'h3;
        4'h6:       cin = 4'h5;
        default:    cin = 4'hF;
      endcase
    end
    return cin;
  endfunction

endpackage

[rtl/msu_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI byte parser
// Tracks running status and data count, and builds a packet when a message
// completes. State updates on every accepted byte.
// ----------------------------------------------------------------------------
module msu_parser import msu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CableWidth-1:0] cfg_wdata_i,
  input  logic                  byte_valid_i,
  input  logic [7:0]            byte_i,
  output logic                  pkt_valid_o,
  output packet_t               pkt_o
);

  logic [CableWidth-1:0] cable_q;
  logic [7:0]            status_q, status_d;
  logic                  seen_q, seen_d;
  logic [1:0]            count_q, count_d;
  logic [6:0]            held_q, held_d;

  logic [7:0] cur_status;
  logic [1:0] len;
  logic [1:0] count_inc;
  logic       complete;

  always_comb begin
    status_d  = status_q;
    seen_d    = seen_q;
    count_d   = count_q;
    held_d    = held_q;
    complete  = 1'b0;
    count_inc = count_q + 2'd1;
    cur_status = byte_i[7] ? byte_i : status_q;
    len       = expected_len(cur_status);
    if (byte_valid_i) begin
      if (byte_i[7]) begin
        status_d = byte_i;
        seen_d   = 1'b1;
        count_d  = 2'd0;
        complete = (len == 2'd0);
      end else if (seen_q && count_q != CountFull) begin
        if (count_q == 2'd0) begin
          held_d = byte_i[6:0];
        end
        count_d = count_inc;
        if (len == count_inc) begin
          complete = 1'b1;
          count_d  = 2'd0;
        end
      end
    end
  end

  // Completions under a SysEx start or end status give no packet.
  assign pkt_valid_o = complete && cur_status != SysexStart && cur_status != SysexEnd;

  always_comb begin
    pkt_o.packet_header = {cable_q, code_index(cur_status)};
    pkt_o.status_byte   = cur_status;
    case (len)
      2'd2: begin
        pkt_o.data_first  = held_q;
        pkt_o.data_second = byte_i[6:0];
      end
      2'd1: begin
        pkt_o.data_first  = byte_i[6:0];
        pkt_o.data_second = 7'd0;
      end
      default: begin
        pkt_o.data_first  = 7'd0;
        pkt_o.data_second = 7'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cable_q  <= '0;
      status_q <= '0;
      seen_q   <= 1'b0;
      count_q  <= '0;
      held_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        cable_q <= cfg_wdata_i;
      end
      status_q <= status_d;
      seen_q   <= seen_d;
      count_q  <= count_d;
      held_q   <= held_d;
    end
  end

endmodule

[rtl/msu_skid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet output buffer
// Output register plus one skid entry, so the parser side keeps taking
// beats while a finished packet waits for the receiver.
// ----------------------------------------------------------------------------
module msu_skid import msu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  packet_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output packet_t out_data_o
);

  logic    out_valid_q;
  logic    skid_valid_q;
  packet_t out_q;
  packet_t skid_q;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_valid_i;
      end
    end else if (in_valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_q <= in_data_i;
    end
  end

endmodule

[rtl/midi_serial_to_usb_packet.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI serial byte stream to USB-MIDI event packet converter
// Turns received MIDI bytes into four-byte USB-MIDI event packets.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream takes one received MIDI byte per beat. A status byte sets
// the running status and clears the data count; data bytes are collected
// until the message is complete, and then one packet beat leaves on the
// master stream. Running status works: further data bytes reuse the last
// status. SysEx start and end bytes give no packet, data bytes seen before
// any status byte are dropped, and unused packet bytes are zero.
// One byte is accepted every cycle while the skid entry is free. A packet
// reaches the master side through the single output register behind the
// parser logic, or through the skid entry while the receiver stalls.
// The cable number register is written through cfg_we_i / cfg_wdata_i and
// should be changed only while no packet is pending.
// Reset clears the running status, the data count, the cable number and
// empties the output stage. When the receiver stalls, the output beat holds
// and one more packet is caught in a skid entry; once that is full,
// s_axis_tready drops until the receiver takes a beat.
// ----------------------------------------------------------------------------
module midi_serial_to_usb_packet import msu_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CableWidth-1:0]    cfg_wdata_i,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [7:0] rx_byte
  input  logic [TdataInWidth-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [7:0] packet_header, [15:8] status_byte, [22:16] data_first,
  // [29:23] data_second, [31:30] zero
  output logic [TdataOutWidth-1:0] m_axis_tdata
);

  logic    byte_accept;
  logic    pkt_valid;
  packet_t pkt;
  packet_t out_pkt;

  // A byte is consumed only when the skid entry has room for its packet.
  assign byte_accept = s_axis_tvalid && s_axis_tready;

  msu_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .byte_valid_i (byte_accept),
    .byte_i       (s_axis_tdata),
    .pkt_valid_o  (pkt_valid),
    .pkt_o        (pkt)
  );

  msu_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pkt_valid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (pkt),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_pkt)
  );

  // Pad the packet up to whole bytes.
  assign m_axis_tdata = {(TdataOutWidth - PacketWidth)'(0), out_pkt};

endmodule

[rtl/msu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI-to-USB packet checker
// Port-level assertions for the converter, bound to its top level.
// ----------------------------------------------------------------------------
module msu_checker import msu_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [TdataOutWidth-1:0] m_axis_tdata
);

  // A stalled beat holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // The input side only backs up while an output beat is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no output beat pending");

  // The status field always carries a status byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15] && m_axis_tdata[31:30] == 2'b00)
    else $error("bad status field or padding");

  // Channel messages carry their high nibble as code index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[15:12] != 4'hF |->
      m_axis_tdata[3:0] == m_axis_tdata[15:12])
    else $error("code index does not match channel message");

  // SysEx start and end never leave as packets.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:8] != SysexStart && m_axis_tdata[15:8] != SysexEnd)
    else $error("SysEx start or end emitted as packet");

endmodule

bind midi_serial_to_usb_packet msu_checker u_msu_checker (.*);
